/* design/tws_pkg.sv */
`timescale 1ns / 1ps

package tws_pkg;

    // Width of the key field on both stream channels
    localparam int DATA_W = 64;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_PIV_RD,
        ST_PIV,
        ST_TEST,
        ST_CMP,
        ST_SW_A,
        ST_SW_B,
        ST_SPLIT,
        ST_POP,
        ST_EM_RD,
        ST_EM_WAIT
    } t_state;

endpackage

/* design/tws_key_mem.sv */
`timescale 1ns / 1ps

module tws_key_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int KW    = 64
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [KW-1:0] i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [KW-1:0] o_rd_data
);

    logic [KW-1:0] r_mem [DEPTH];
    logic [KW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

/* design/tws_range_stack.sv */
`timescale 1ns / 1ps

module tws_range_stack #(
    parameter int CW = 7,
    parameter int SD = 6
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  logic          i_pop,
    input  logic [CW-1:0] i_lo,
    input  logic [CW-1:0] i_hi,
    output logic [CW-1:0] o_lo,
    output logic [CW-1:0] o_hi,
    output logic          o_empty
);

    localparam int SPW = $clog2(SD + 1);
    localparam int IW  = (SD > 1) ? $clog2(SD) : 1;

    logic [CW-1:0]  r_lo [SD];
    logic [CW-1:0]  r_hi [SD];
    logic [SPW-1:0] r_sp;
    logic [SPW-1:0] top;

    assign top = r_sp - SPW'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp <= '0;
        end else if (i_push && (r_sp < SPW'(SD))) begin
            r_sp <= r_sp + SPW'(1);
        end else if (i_pop && (r_sp != '0)) begin
            r_sp <= r_sp - SPW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && (r_sp < SPW'(SD))) begin
            r_lo[r_sp[IW-1:0]] <= i_lo;
            r_hi[r_sp[IW-1:0]] <= i_hi;
        end
    end

    assign o_lo    = r_lo[top[IW-1:0]];
    assign o_hi    = r_hi[top[IW-1:0]];
    assign o_empty = (r_sp == '0);

endmodule

/* design/three_way_quicksort_engine.sv */
`timescale 1ns / 1ps
// Three-way quicksort engine.
// Input stream: one key per item on s_tdata, s_tlast ends the set. The set
// also ends on the item that fills the store (MAX_ITEMS keys). Keys are cut
// to KEY_BITS and compared unsigned.
// Output stream: the keys of the set in ascending order, m_tlast on the last.
// Loading takes one key per cycle; s_tready is high only while loading.
// After the final key the block sorts in place with one key memory (one
// read, one write port) and one pair of key comparators under a sequencer:
// each range reads its middle key as pivot, then compares each element;
// one equal to the pivot stays, one that moves is swapped in two writes.
// The range then splits, pushing the larger part on the stack. Once sorted,
// the keys drain in order, each read from the memory and then emitted.
// A stalled receiver holds the output register; the drain waits with it.
// The last result may still wait while the next set loads.
// Reset (synchronous, active low) empties the store, clears the stack and
// drops m_tvalid; store contents are left as they are.
module three_way_quicksort_engine #(
    parameter int MAX_ITEMS = 64,
    parameter int KEY_BITS  = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [tws_pkg::DATA_W-1:0]  i_s_tdata,  // [63:0] key
    input  logic                        i_s_tlast,  // last
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [tws_pkg::DATA_W-1:0]  o_m_tdata,  // [63:0] key_res
    output logic                        o_m_tlast   // last_res
);

    import tws_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int SD = $clog2(MAX_ITEMS);

    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [CW-1:0] r_le, n_le, r_sc, n_sc, r_gs, n_gs;
    logic [CW-1:0] r_ia, n_ia, r_ib, n_ib;
    logic [CW-1:0] r_idx, n_idx;
    logic [KEY_BITS-1:0] r_key, n_key, r_pivot, n_pivot;
    logic          r_out_valid, n_out_valid;
    logic [KEY_BITS-1:0] r_out_key, n_out_key;
    logic          r_out_last, n_out_last;

    logic                wr_en;
    logic [AW-1:0]       wr_addr, rd_addr;
    logic [KEY_BITS-1:0] wr_data, rd_data;
    logic                stk_push, stk_pop, stk_empty;
    logic [CW-1:0]       stk_lo_in, stk_hi_in, stk_lo, stk_hi;

    logic          key_gt, key_lt;
    logic [CW-1:0] load_n, mid, lsz, rsz;
    logic          out_free;

    tws_key_mem #(.DEPTH(MAX_ITEMS), .AW(AW), .KW(KEY_BITS)) u_mem (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    tws_range_stack #(.CW(CW), .SD(SD)) u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (stk_push),
        .i_pop   (stk_pop),
        .i_lo    (stk_lo_in),
        .i_hi    (stk_hi_in),
        .o_lo    (stk_lo),
        .o_hi    (stk_hi),
        .o_empty (stk_empty)
    );

    // comparator pair: memory read data against the pivot, greater and less
    assign key_gt = (rd_data > r_pivot);
    assign key_lt = (rd_data < r_pivot);

    assign load_n   = r_count + CW'(1);
    assign mid      = r_lo + ((r_hi - r_lo) >> 1);
    assign lsz      = r_le - r_lo;
    assign rsz      = r_hi - r_gs;
    assign out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_le       <= n_le;
        r_sc       <= n_sc;
        r_gs       <= n_gs;
        r_ia       <= n_ia;
        r_ib       <= n_ib;
        r_idx      <= n_idx;
        r_key      <= n_key;
        r_pivot    <= n_pivot;
        r_out_key  <= n_out_key;
        r_out_last <= n_out_last;
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_le        = r_le;
        n_sc        = r_sc;
        n_gs        = r_gs;
        n_ia        = r_ia;
        n_ib        = r_ib;
        n_idx       = r_idx;
        n_key       = r_key;
        n_pivot     = r_pivot;
        n_out_valid = r_out_valid;
        n_out_key   = r_out_key;
        n_out_last  = r_out_last;
        wr_en       = 1'b0;
        wr_addr     = r_count[AW-1:0];
        wr_data     = i_s_tdata[KEY_BITS-1:0];
        rd_addr     = r_sc[AW-1:0];
        stk_push    = 1'b0;
        stk_pop     = 1'b0;
        stk_lo_in   = r_lo;
        stk_hi_in   = r_le;

        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_LOAD: begin
                if (i_s_tvalid) begin
                    wr_en   = 1'b1;
                    n_count = load_n;
                    if (i_s_tlast || (load_n == CW'(MAX_ITEMS))) begin
                        n_lo  = '0;
                        n_hi  = load_n;
                        n_idx = '0;
                        n_state = (load_n > CW'(1)) ? ST_PIV_RD : ST_EM_RD;
                    end
                end
            end
            ST_PIV_RD: begin
                rd_addr = mid[AW-1:0];
                n_state = ST_PIV;
            end
            ST_PIV: begin
                n_pivot = rd_data;
                n_le    = r_lo;
                n_sc    = r_lo;
                n_gs    = r_hi;
                n_state = ST_TEST;
            end
            ST_TEST: begin
                rd_addr = r_sc[AW-1:0];
                n_state = (r_sc < r_gs) ? ST_CMP : ST_SPLIT;
            end
            ST_CMP: begin
                n_key = rd_data;
                n_ia  = r_sc;
                if (key_gt) begin
                    // swap with the element just below the greater part
                    n_gs    = r_gs - CW'(1);
                    n_ib    = r_gs - CW'(1);
                    rd_addr = n_ib[AW-1:0];
                    n_state = ST_SW_A;
                end else if (key_lt) begin
                    n_ib    = r_le;
                    rd_addr = r_le[AW-1:0];
                    n_le    = r_le + CW'(1);
                    n_sc    = r_sc + CW'(1);
                    n_state = ST_SW_A;
                end else begin
                    n_sc    = r_sc + CW'(1);
                    n_state = ST_TEST;
                end
            end
            ST_SW_A: begin
                wr_en   = 1'b1;
                wr_addr = r_ia[AW-1:0];
                wr_data = rd_data;
                n_state = ST_SW_B;
            end
            ST_SW_B: begin
                wr_en   = 1'b1;
                wr_addr = r_ib[AW-1:0];
                wr_data = r_key;
                n_state = ST_TEST;
            end
            ST_SPLIT: begin
                // push the larger part, keep working on the smaller one
                if (lsz >= rsz) begin
                    stk_push  = (lsz > CW'(1));
                    stk_lo_in = r_lo;
                    stk_hi_in = r_le;
                    n_lo      = r_gs;
                    if (rsz > CW'(1)) begin
                        n_state = ST_PIV_RD;
                    end else begin
                        n_state = (stk_empty && !stk_push) ? ST_EM_RD : ST_POP;
                    end
                end else begin
                    stk_push  = (rsz > CW'(1));
                    stk_lo_in = r_gs;
                    stk_hi_in = r_hi;
                    n_hi      = r_le;
                    if (lsz > CW'(1)) begin
                        n_state = ST_PIV_RD;
                    end else begin
                        n_state = (stk_empty && !stk_push) ? ST_EM_RD : ST_POP;
                    end
                end
                n_idx = '0;
            end
            ST_POP: begin
                stk_pop = 1'b1;
                n_lo    = stk_lo;
                n_hi    = stk_hi;
                n_state = ST_PIV_RD;
            end
            ST_EM_RD: begin
                rd_addr = r_idx[AW-1:0];
                n_state = ST_EM_WAIT;
            end
            ST_EM_WAIT: begin
                rd_addr = r_idx[AW-1:0];
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_key   = rd_data;
                    n_out_last  = (load_n == CW'(0)) ? 1'b0 : (r_idx == r_count - CW'(1));
                    n_idx       = r_idx + CW'(1);
                    if (r_idx == r_count - CW'(1)) begin
                        n_count = '0;
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_EM_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    assign o_s_tready = (r_state == ST_LOAD);
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = DATA_W'(r_out_key);
    assign o_m_tlast  = r_out_last;

endmodule

/* bench/three_way_quicksort_engine_tb.sv */
`timescale 1ns / 1ps

module three_way_quicksort_engine_tb;
    import tws_pkg::*;

    localparam int MAX_ITEMS    = 64;
    localparam int KEY_BITS     = 64;
    localparam int RANDOM_ITEMS = 350;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 60000;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [DATA_W-1:0] KEY_MASK = {DATA_W{1'b1}} >> (DATA_W - KEY_BITS);

    typedef struct packed {
        logic [DATA_W-1:0] key;
        logic              last;
    } t_sorted_key;

    typedef enum int {
        KEY_RANDOM,
        KEY_FEW,
        KEY_ASCEND,
        KEY_DESCEND,
        KEY_TEXT,
        KEY_EDGE
    } t_key_mode;

    // Collects the keys of the set being loaded; on set end, sorts them and
    // queues them as the keys the block must return.
    class sort_scoreboard;
        logic [DATA_W-1:0] loading_keys[$];
        t_sorted_key       sorted_keys[$];
        int                errors;

        function new();
            errors = 0;
        endfunction

        function void note_key(logic [DATA_W-1:0] key, logic last);
            logic [DATA_W-1:0] k;
            t_sorted_key       entry;
            int                j;
            loading_keys.push_back(key & KEY_MASK);
            if (!last && loading_keys.size() < MAX_ITEMS)
                return;
            for (int i = 1; i < loading_keys.size(); i++) begin
                k = loading_keys[i];
                j = i;
                while (j > 0 && loading_keys[j-1] > k) begin
                    loading_keys[j] = loading_keys[j-1];
                    j--;
                end
                loading_keys[j] = k;
            end
            for (int i = 0; i < loading_keys.size(); i++) begin
                entry.key  = loading_keys[i];
                entry.last = (i == loading_keys.size() - 1);
                sorted_keys.push_back(entry);
            end
            loading_keys.delete();
        endfunction

        function void check_result(logic [DATA_W-1:0] key, logic last);
            t_sorted_key want;
            if (sorted_keys.size() == 0) begin
                $display("%0t: unexpected item, expected none, got key %h last %b",
                         $time, key, last);
                errors++;
                return;
            end
            want = sorted_keys.pop_front();
            if (want.key !== key || want.last !== last) begin
                $display("%0t: sorted key mismatch, expected key %h last %b, got key %h last %b",
                         $time, want.key, want.last, key, last);
                errors++;
            end
        endfunction

        function int pending();
            return sorted_keys.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_s_tvalid;
    logic              o_s_tready;
    logic [DATA_W-1:0] i_s_tdata;   // [63:0] key
    logic              i_s_tlast;   // last
    logic              o_m_tvalid;
    logic              i_m_tready;
    logic [DATA_W-1:0] o_m_tdata;   // [63:0] key_res
    logic              o_m_tlast;   // last_res

    sort_scoreboard sb;
    int             items_sent;
    int             results_seen;
    int             idle_cycles;
    bit             sender_calm;

    three_way_quicksort_engine #(
        .MAX_ITEMS(MAX_ITEMS),
        .KEY_BITS (KEY_BITS)
    ) i_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tlast (i_s_tlast),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tlast (o_m_tlast)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // mostly no gap or a short one, now and then a long one
    function automatic int pick_gap(bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // big-endian, zero padded: byte 0 of the text lands in the top byte
    function automatic logic [DATA_W-1:0] pack_text(string s);
        logic [DATA_W-1:0] key;
        key = '0;
        for (int i = 0; i < 8; i++)
            key = {key[DATA_W-9:0], (i < s.len()) ? 8'(s[i]) : 8'h00};
        return key;
    endfunction

    function automatic logic [DATA_W-1:0] make_key(t_key_mode mode, int idx,
                                                   logic [DATA_W-1:0] base);
        logic [DATA_W-1:0] key;
        int                len;
        case (mode)
            KEY_FEW: begin
                key = (64'($urandom_range(0, 3)) << 62) | 64'($urandom_range(0, 2));
            end
            KEY_ASCEND: begin
                key = base + 64'(idx);
            end
            KEY_DESCEND: begin
                key = base - 64'(idx);
            end
            KEY_TEXT: begin
                len = $urandom_range(0, 8);
                key = '0;
                for (int i = 0; i < 8; i++)
                    key = {key[DATA_W-9:0], (i < len) ? 8'($urandom_range(97, 100)) : 8'h00};
            end
            KEY_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       key = '0;
                    1:       key = '1;
                    2:       key = 64'h1;
                    3:       key = 64'h8000_0000_0000_0000;
                    default: key = 64'h7FFF_FFFF_FFFF_FFFF;
                endcase
            end
            default: begin
                key = {$urandom, $urandom};
            end
        endcase
        return key;
    endfunction

    task automatic offer_key(input logic [DATA_W-1:0] key, input logic last);
        int gap;
        gap = pick_gap(sender_calm);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= key;
        i_s_tlast  <= last;
        do @(posedge i_clk); while (!o_s_tready);
        @(negedge i_clk);
        items_sent++;
    endtask

    task automatic offer_set(input logic [DATA_W-1:0] keys[$]);
        for (int i = 0; i < keys.size(); i++)
            offer_key(keys[i], i == keys.size() - 1);
    endtask

    // both handshakes are observed here on the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                sb.check_result(o_m_tdata, o_m_tlast);
                results_seen++;
            end
            if (i_s_tvalid && o_s_tready)
                sb.note_key(i_s_tdata, i_s_tlast);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, no item moved for %0d cycles", $time, idle_cycles);
            $display("Mismatches found");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // receiver: random stalls, calm stretches, and one long hold-off so the
    // block backs up into its input
    initial begin
        int stall_left;
        int tick;
        bit calm;
        bit held;
        stall_left = 0;
        tick       = 0;
        calm       = 1'b0;
        held       = 1'b0;
        i_m_tready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            tick++;
            if (tick % 150 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (!held && results_seen >= 40) begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
                stall_left = pick_gap(1'b0);
            end
            if (stall_left > 0) begin
                i_m_tready <= 1'b0;
                stall_left--;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    initial begin
        logic [DATA_W-1:0] keys[$];
        logic [DATA_W-1:0] base;
        t_key_mode         mode;
        int                set_size;
        logic              fill_last;

        sb           = new();
        items_sent   = 0;
        sender_calm  = 1'b0;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        i_s_tlast    = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // single-key sets at both extremes
        keys = '{64'h0};
        offer_set(keys);
        keys = '{64'hFFFF_FFFF_FFFF_FFFF};
        offer_set(keys);
        // extremes and the sign bit, compared unsigned
        keys = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h8000_0000_0000_0000, 64'h1};
        offer_set(keys);
        // all keys equal
        keys = '{5{64'h5555_AAAA_5555_AAAA}};
        offer_set(keys);
        keys = '{2{64'hFFFF_FFFF_FFFF_FFFF}};
        offer_set(keys);
        // text keys with a shared prefix
        keys = '{pack_text("banana"), pack_text("apple"), pack_text("cherry"),
                 pack_text("app")};
        offer_set(keys);
        // reverse order
        keys = '{64'h50, 64'h40, 64'h30, 64'h20, 64'h10};
        offer_set(keys);

        // random sets, now and then one that fills the store
        while (items_sent < RANDOM_ITEMS) begin
            mode        = t_key_mode'($urandom_range(0, 5));
            base        = {$urandom, $urandom};
            sender_calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 11) == 0)
                set_size = MAX_ITEMS;
            else
                set_size = $urandom_range(1, 16);
            fill_last = $urandom_range(0, 1);
            for (int i = 0; i < set_size; i++) begin
                if (i < set_size - 1)
                    offer_key(make_key(mode, i, base), 1'b0);
                else
                    offer_key(make_key(mode, i, base),
                              (set_size == MAX_ITEMS) ? fill_last : 1'b1);
            end
        end
        i_s_tvalid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* three_way_quicksort_engine.f */
design/tws_pkg.sv
design/tws_key_mem.sv
design/tws_range_stack.sv
design/three_way_quicksort_engine.sv
bench/three_way_quicksort_engine_tb.sv
